// File: sv/tlik_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the
// two-link arm inverse kinematics unit. No dependencies.
`default_nettype none
package tlik_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int CORDIC_W   = 45;   // CORDIC x/y datapath width
    localparam int ANGLE_W    = 32;   // angle accumulator, 2^-20 degree
    localparam int OPER_W     = 34;   // signed CORDIC operand width
    localparam int NORM_EXP   = 40;   // normalize until a magnitude reaches 2^40

    localparam logic signed [ANGLE_W-1:0] ANG_90 = 32'sd94371840;

    localparam logic [1:0] CFG_UPPER = 2'd0;
    localparam logic [1:0] CFG_LOWER = 2'd1;

    localparam logic [14:0] LINK_RESET = 15'd1600;

    localparam logic signed [32:0] EL_MAX = 33'sd23040;
    localparam logic signed [32:0] SH_MIN = -33'sd23040;
    localparam logic signed [32:0] SH_MAX = 33'sd46080;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MXX, ST_MYY, ST_D2, ST_MUU, ST_MLL, ST_MLO, ST_MHI, ST_CHK,
        ST_MUL, ST_MDE, ST_MNE, ST_RAD1, ST_SQ1, ST_SQ1W, ST_COR1, ST_COR1W,
        ST_MDS, ST_MNS, ST_RAD2, ST_SQ2, ST_SQ2W, ST_COR2, ST_COR2W,
        ST_COR3, ST_COR3W, ST_FIN
    } t_ik_state;

    typedef enum logic [1:0] {
        C_IDLE, C_NORM, C_PRE, C_ITER
    } t_cordic_state;

    // atan(2^-i) in 2^-20 degree
    function automatic logic [25:0] atan_tab(input logic [4:0] i);
        logic [25:0] v;
        case (i)
            5'd0:  v = 26'd47185920;
            5'd1:  v = 26'd27855475;
            5'd2:  v = 26'd14718068;
            5'd3:  v = 26'd7471121;
            5'd4:  v = 26'd3750058;
            5'd5:  v = 26'd1876857;
            5'd6:  v = 26'd938658;
            5'd7:  v = 26'd469357;
            5'd8:  v = 26'd234682;
            5'd9:  v = 26'd117342;
            5'd10: v = 26'd58671;
            5'd11: v = 26'd29335;
            5'd12: v = 26'd14668;
            5'd13: v = 26'd7334;
            5'd14: v = 26'd3667;
            5'd15: v = 26'd1833;
            5'd16: v = 26'd917;
            5'd17: v = 26'd458;
            5'd18: v = 26'd229;
            5'd19: v = 26'd115;
            5'd20: v = 26'd57;
            5'd21: v = 26'd29;
            5'd22: v = 26'd14;
            5'd23: v = 26'd7;
            5'd24: v = 26'd4;
            5'd25: v = 26'd2;
            5'd26: v = 26'd1;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: sv/tlik_isqrt.sv
// Bit-serial integer square root (floor), one result bit per step.
// Depends on nothing but the clock and reset.
`default_nettype none
module tlik_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_done,
    output logic [31:0]      o_root
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [63:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // flag the last step for one cycle
            r_done <= r_busy && !i_start && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_val;
                r_r    <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v <= r_v - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];
endmodule
`default_nettype wire

// File: sv/tlik_cordic.sv
// Iterative vectoring CORDIC atan2 with bit-at-a-time normalization.
// Depends on tlik_pkg (widths, state type, arctangent table).
`default_nettype none
module tlik_cordic
    import tlik_pkg::*;
#(
    parameter int ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic signed [OPER_W-1:0]   i_y,
    input  wire logic signed [OPER_W-1:0]   i_x,
    output logic                            o_done,
    output logic signed [ANGLE_W-1:0]       o_angle
);
    localparam int CNT_W = $clog2(ITERATIONS + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ITERATIONS - 1);

    t_cordic_state r_state, n_state;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic signed [CORDIC_W-1:0]  r_x, r_y;
    logic signed [ANGLE_W-1:0]   r_z;
    logic signed [CORDIC_W-1:0]  dx, dy;
    logic                        x_small, y_small, zero_in, done_c;
    logic [4:0]                  tab_idx;
    logic signed [ANGLE_W-1:0]   tab_val;

    function automatic logic mag_small(input logic signed [CORDIC_W-1:0] v);
        logic [CORDIC_W-NORM_EXP-1:0] top;
        top = v[CORDIC_W-1:NORM_EXP];
        return (top == '0) || ((&top) && (v[NORM_EXP-1:0] != '0));
    endfunction

    assign x_small = mag_small(r_x);
    assign y_small = mag_small(r_y);
    assign zero_in = (i_x == '0) && (i_y == '0);
    assign dx      = r_y >>> r_cnt;
    assign dy      = r_x >>> r_cnt;
    assign tab_idx = 5'(r_cnt);
    assign tab_val = ANGLE_W'(atan_tab(tab_idx));
    // zero vector finishes at once, otherwise after the last rotation
    assign done_c  = ((r_state == C_IDLE) && i_start && zero_in)
                   || ((r_state == C_ITER) && (r_cnt == LAST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= C_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE: if (i_start && !zero_in) n_state = C_NORM;
            C_NORM: if (!(x_small && y_small)) n_state = C_PRE;
            C_PRE:  n_state = C_ITER;
            C_ITER: if (r_cnt == LAST) n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= done_c;
            case (r_state)
                C_IDLE: if (i_start) begin
                    r_x   <= CORDIC_W'(i_x);
                    r_y   <= CORDIC_W'(i_y);
                    r_z   <= '0;
                    r_cnt <= '0;
                end
                C_NORM: if (x_small && y_small) begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end
                C_PRE: if (r_x < 0) begin
                    // turn into the right half plane
                    if (r_y >= 0) begin
                        r_x <= r_y;
                        r_y <= -r_x;
                        r_z <= ANG_90;
                    end else begin
                        r_x <= -r_y;
                        r_y <= r_x;
                        r_z <= -ANG_90;
                    end
                end
                C_ITER: begin
                    if (r_y >= 0) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + tab_val;
                    end else begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - tab_val;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_z;
endmodule
`default_nettype wire

// File: sv/two_link_arm_inverse_kinematics_unit.sv
// Top level of the two-link arm inverse kinematics unit: sequencer, shared
// multiplier and output register. Depends on tlik_pkg, tlik_isqrt, tlik_cordic.
`default_nettype none
// Takes a target point (x, y) in 1/16 mm and returns the shoulder and elbow
// angles of a two-link planar arm in 1/128 degree. A target equal to the
// previous accepted one (reset value all ones) is dropped with no result.
// Targets that are out of reach, at the origin, or with a zero link length
// give one word with unreachable set and both angles zero. The block handles
// one target at a time: o_in_ready is high only while the sequencer is idle.
// A reachable target uses the shared multiplier, two square roots of 32
// steps each and three CORDIC passes (start, normalize doublings, a quarter
// turn, the rotations, done); small operands need the most normalize
// doublings and large operands fewer. The serial CORDIC and square root
// units take most of a solve. An unreachable target skips the square roots
// and CORDIC passes. A finished word waits in the output register; the next
// target is taken once the result is loaded there.
module two_link_arm_inverse_kinematics_unit
    import tlik_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_target_x,
    input  wire logic signed [15:0] i_target_y,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [16:0]      o_shoulder_angle,
    output logic [14:0]             o_elbow_angle,
    output logic                    o_unreachable,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [14:0]        i_cfg_data
);
    t_ik_state r_state, n_state;

    // configuration and last-target state
    logic [14:0]        r_upper, r_lower;
    logic [15:0]        r_last_x, r_last_y;

    // datapath registers
    logic signed [15:0] r_x, r_y;
    logic [31:0]        r_t1, r_t2, r_d2, r_uu, r_ll, r_lo, r_hi, r_de;
    logic [63:0]        r_den, r_an2, r_rad;
    logic signed [33:0] r_ne, r_ns;
    logic [31:0]        r_s;
    logic signed [ANGLE_W-1:0] r_zel, r_zsh;
    logic               r_unr;

    // output register
    logic               r_out_valid;
    logic signed [16:0] r_sh_out;
    logic [14:0]        r_el_out;
    logic               r_unr_out;

    // shared multiplier
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;

    logic [16:0]        ax17, ay17;
    logic [15:0]        diff_ul, sum_ul;
    logic [14:0]        adiff;
    logic signed [33:0] ne_c, ns_c, ne_abs, ns_abs;
    logic               unreach_c, accept, repeat_t, out_free;

    logic               sq_start, sq_done;
    logic [31:0]        sq_root;
    logic               co_start, co_done;
    logic signed [OPER_W-1:0]  co_y, co_x;
    logic signed [ANGLE_W-1:0] co_angle;

    logic signed [32:0] el_sum, sh_sum, el_r, sh_r;
    logic signed [32:0] el_cl, sh_cl;

    assign ax17    = r_x[15] ? 17'(-$signed({r_x[15], r_x})) : {1'b0, r_x};
    assign ay17    = r_y[15] ? 17'(-$signed({r_y[15], r_y})) : {1'b0, r_y};
    assign diff_ul = {1'b0, r_upper} - {1'b0, r_lower};
    assign adiff   = diff_ul[15] ? 15'(-diff_ul) : diff_ul[14:0];
    assign sum_ul  = {1'b0, r_upper} + {1'b0, r_lower};
    assign ne_c    = $signed({2'b0, r_uu}) + $signed({2'b0, r_ll}) - $signed({2'b0, r_d2});
    assign ns_c    = $signed({2'b0, r_d2}) + $signed({2'b0, r_uu}) - $signed({2'b0, r_ll});
    assign ne_abs  = r_ne[33] ? -r_ne : r_ne;
    assign ns_abs  = r_ns[33] ? -r_ns : r_ns;
    assign unreach_c = (r_upper == '0) || (r_lower == '0) || (r_d2 == '0)
                     || (r_d2 < r_lo) || (r_d2 > r_hi);

    assign accept   = i_in_valid && o_in_ready;
    assign repeat_t = (i_target_x == r_last_x) && (i_target_y == r_last_y);
    assign out_free = !r_out_valid || i_out_ready;

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MXX: begin mul_a = {16'b0, ax17[15:0]}; mul_b = {16'b0, ax17[15:0]}; end
            ST_MYY: begin mul_a = {16'b0, ay17[15:0]}; mul_b = {16'b0, ay17[15:0]}; end
            ST_MUU: begin mul_a = {17'b0, r_upper}; mul_b = {17'b0, r_upper}; end
            ST_MLL: begin mul_a = {17'b0, r_lower}; mul_b = {17'b0, r_lower}; end
            ST_MLO: begin mul_a = {17'b0, adiff}; mul_b = {17'b0, adiff}; end
            ST_MHI: begin mul_a = {16'b0, sum_ul}; mul_b = {16'b0, sum_ul}; end
            ST_MUL: begin mul_a = {17'b0, r_upper}; mul_b = {17'b0, r_lower}; end
            ST_MDE: begin mul_a = r_de; mul_b = r_de; end
            ST_MNE: begin mul_a = ne_abs[31:0]; mul_b = ne_abs[31:0]; end
            ST_MDS: begin mul_a = r_d2; mul_b = r_uu; end
            ST_MNS: begin mul_a = ns_abs[31:0]; mul_b = ns_abs[31:0]; end
            default: ;
        endcase
    end
    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    // operand select for the shared CORDIC
    always_comb begin
        co_y = OPER_W'(r_y);
        co_x = OPER_W'(r_x);
        case (r_state)
            ST_COR1: begin co_y = $signed({2'b0, r_s}); co_x = r_ne; end
            ST_COR2: begin co_y = $signed({2'b0, r_s}); co_x = r_ns; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        sq_start   = 1'b0;
        co_start   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && !repeat_t) n_state = ST_MXX;
            end
            ST_MXX:  n_state = ST_MYY;
            ST_MYY:  n_state = ST_D2;
            ST_D2:   n_state = ST_MUU;
            ST_MUU:  n_state = ST_MLL;
            ST_MLL:  n_state = ST_MLO;
            ST_MLO:  n_state = ST_MHI;
            ST_MHI:  n_state = ST_CHK;
            ST_CHK:  n_state = unreach_c ? ST_FIN : ST_MUL;
            ST_MUL:  n_state = ST_MDE;
            ST_MDE:  n_state = ST_MNE;
            ST_MNE:  n_state = ST_RAD1;
            ST_RAD1: n_state = ST_SQ1;
            ST_SQ1:  begin sq_start = 1'b1; n_state = ST_SQ1W; end
            ST_SQ1W: if (sq_done) n_state = ST_COR1;
            ST_COR1: begin co_start = 1'b1; n_state = ST_COR1W; end
            ST_COR1W: if (co_done) n_state = ST_MDS;
            ST_MDS:  n_state = ST_MNS;
            ST_MNS:  n_state = ST_RAD2;
            ST_RAD2: n_state = ST_SQ2;
            ST_SQ2:  begin sq_start = 1'b1; n_state = ST_SQ2W; end
            ST_SQ2W: if (sq_done) n_state = ST_COR2;
            ST_COR2: begin co_start = 1'b1; n_state = ST_COR2W; end
            ST_COR2W: if (co_done) n_state = ST_COR3;
            ST_COR3: begin co_start = 1'b1; n_state = ST_COR3W; end
            ST_COR3W: if (co_done) n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // round 2^-20 degree to 1/128 degree, then clamp
    assign el_sum = 33'(r_zel) + 33'sd4096;
    assign sh_sum = 33'(r_zsh) + 33'sd4096;
    assign el_r   = el_sum >>> 13;
    assign sh_r   = sh_sum >>> 13;
    assign el_cl  = (el_r < 0) ? '0 : ((el_r > EL_MAX) ? EL_MAX : el_r);
    assign sh_cl  = (sh_r < SH_MIN) ? SH_MIN : ((sh_r > SH_MAX) ? SH_MAX : sh_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper     <= LINK_RESET;
            r_lower     <= LINK_RESET;
            r_last_x    <= '1;
            r_last_y    <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_UPPER: r_upper <= i_cfg_data;
                    CFG_LOWER: r_lower <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_last_x <= i_target_x;
                r_last_y <= i_target_y;
                r_x      <= i_target_x;
                r_y      <= i_target_y;
            end
            // drop the word once taken, unless a new one replaces it
            if (r_out_valid && i_out_ready && (r_state != ST_FIN)) r_out_valid <= 1'b0;
            case (r_state)
                ST_MXX:  r_t1 <= mul_p[31:0];
                ST_MYY:  r_t2 <= mul_p[31:0];
                ST_D2:   r_d2 <= r_t1 + r_t2;
                ST_MUU:  r_uu <= mul_p[31:0];
                ST_MLL:  r_ll <= mul_p[31:0];
                ST_MLO:  r_lo <= mul_p[31:0];
                ST_MHI:  r_hi <= mul_p[31:0];
                ST_CHK: begin
                    r_unr <= unreach_c;
                    r_ne  <= ne_c;
                    r_ns  <= ns_c;
                end
                ST_MUL:  r_de  <= {mul_p[30:0], 1'b0};
                ST_MDE:  r_den <= mul_p;
                ST_MNE:  r_an2 <= mul_p;
                ST_RAD1: r_rad <= r_den - r_an2;
                ST_SQ1W: if (sq_done) r_s <= sq_root;
                ST_COR1W: if (co_done) r_zel <= co_angle;
                ST_MDS:  r_den <= {mul_p[61:0], 2'b0};
                ST_MNS:  r_an2 <= mul_p;
                ST_RAD2: r_rad <= r_den - r_an2;
                ST_SQ2W: if (sq_done) r_s <= sq_root;
                ST_COR2W: if (co_done) r_zsh <= co_angle;
                ST_COR3W: if (co_done) r_zsh <= r_zsh + co_angle;
                ST_FIN: if (out_free) begin
                    // load the result word, dropping angles when unreachable
                    r_out_valid <= 1'b1;
                    r_unr_out   <= r_unr;
                    r_sh_out    <= r_unr ? '0 : sh_cl[16:0];
                    r_el_out    <= r_unr ? '0 : el_cl[14:0];
                end
                default: ;
            endcase
        end
    end

    tlik_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (r_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    tlik_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (co_start),
        .i_y     (co_y),
        .i_x     (co_x),
        .o_done  (co_done),
        .o_angle (co_angle)
    );

    assign o_out_valid      = r_out_valid;
    assign o_shoulder_angle = r_sh_out;
    assign o_elbow_angle    = r_el_out;
    assign o_unreachable    = r_unr_out;
endmodule
`default_nettype wire

// File: bench/tb.sv
// Testbench for two_link_arm_inverse_kinematics_unit: directed table, then random
// targets over several link settings, checked against a bit-true angle predictor.
// Depends on tlik_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb
    import tlik_pkg::*;
;

    localparam int  DRAIN_CYCLES = 400;     // longest single solve, with margin
    localparam int  STALL_LIMIT  = 20000;   // cycles without any handshake
    localparam int  CORDIC_STEPS = 16;

    typedef struct packed {
        logic signed [16:0] shoulder;
        logic [14:0]        elbow;
        logic               unreach;
    } t_angles;

    // how a directed row is checked
    typedef enum int {ROW_PREDICT, ROW_DROPPED, ROW_UNREACH} t_row_kind;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        t_row_kind          kind;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_target_x;
    logic signed [15:0] i_target_y;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [16:0] o_shoulder_angle;
    logic [14:0]        o_elbow_angle;
    logic               o_unreachable;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [14:0]        i_cfg_data;

    two_link_arm_inverse_kinematics_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_target_x       (i_target_x),
        .i_target_y       (i_target_y),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_shoulder_angle (o_shoulder_angle),
        .o_elbow_angle    (o_elbow_angle),
        .o_unreachable    (o_unreachable),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Predictor state: link lengths and the last target seen.
    logic [14:0] upper_len;
    logic [14:0] lower_len;
    logic [15:0] prev_x;
    logic [15:0] prev_y;

    t_angles angle_q[$];   // expected angle words, oldest first
    int      n_errors;
    int      idle_cycles;

    // atan(2^-i) in 2^-20 degree
    longint arctan_lut[32] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7,
        4, 2, 1, 0, 0, 0, 0, 0
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Vectoring arctangent, result in 2^-20 degree.
    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        while (mag(x) < (64'sd1 <<< 40) && mag(y) < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
        end
        // fold the left half-plane by a quarter turn
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;  y = -t; z = 90 * 64'sd1048576;
            end else begin
                x = -y; y = t;  z = -90 * 64'sd1048576;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + arctan_lut[i];
            end else begin
                x = x - dx; y = y + dy; z = z - arctan_lut[i];
            end
        end
        return z;
    endfunction

    // acos(n / sqrt(den_sq)) as atan2(sqrt(den_sq - n^2), n)
    function automatic longint cos_law_angle(longint n, longint unsigned den_sq);
        longint unsigned an;
        longint unsigned s;
        an = (n < 0) ? -n : n;
        s  = int_sqrt(den_sq - an * an);
        return vector_angle(longint'(s), n);
    endfunction

    // Solve one target; produced = 0 when the target repeats the last one.
    function automatic t_angles ik_solve(logic signed [15:0] tx, logic signed [15:0] ty,
                                         output bit produced);
        t_angles r;
        longint  x, y, u, l, d2, lo, hi, sh, el, ne, ns;
        longint unsigned de, ds2;
        x = tx; y = ty; u = upper_len; l = lower_len;
        r = '0;
        produced = 0;
        if (tx == prev_x && ty == prev_y) return r;
        prev_x = tx;
        prev_y = ty;
        produced = 1;
        d2 = x * x + y * y;
        lo = (u - l) * (u - l);
        hi = (u + l) * (u + l);
        if (u == 0 || l == 0 || d2 == 0 || d2 < lo || d2 > hi) begin
            r.unreach = 1'b1;
            return r;
        end
        ne  = u * u + l * l - d2;
        de  = 2 * u * l;
        ns  = d2 + u * u - l * l;
        ds2 = 4 * longint'(d2) * longint'(u * u);
        el  = (cos_law_angle(ne, de * de) + 4096) >>> 13;
        sh  = (vector_angle(y, x) + cos_law_angle(ns, ds2) + 4096) >>> 13;
        if (el < 0) el = 0;
        if (el > 23040) el = 23040;
        if (sh < -23040) sh = -23040;
        if (sh > 46080) sh = 46080;
        r.shoulder = sh[16:0];
        r.elbow    = el[14:0];
        return r;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // Drive one target word; predict once it is accepted.
    task automatic send_target(logic signed [15:0] tx, logic signed [15:0] ty,
                               t_row_kind kind);
        int      n;
        bit      produced;
        t_angles r;
        @(negedge i_clk);
        n = pick_gap();
        if (n > 0) begin
            i_in_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_target_x = tx;
        i_target_y = ty;
        i_in_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        r = ik_solve(tx, ty, produced);
        if (kind == ROW_UNREACH) begin
            angle_q.push_back('{shoulder: '0, elbow: '0, unreach: 1'b1});
        end else if (kind == ROW_PREDICT && produced) begin
            angle_q.push_back(r);
        end
    endtask

    // Write a register once every word is out and the block has settled.
    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (angle_q.size() != 0) @(negedge i_clk);
        // a dropped repeat leaves nothing to wait on, so hold off a full solve
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        if (idx == CFG_UPPER) upper_len = val;
        else if (idx == CFG_LOWER) lower_len = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Random target: mostly near the reachable annulus, some raw noise and repeats.
    task automatic send_random();
        int p;
        longint lo, hi, r, x, y;
        p = $urandom_range(0, 99);
        if (p < 6) begin
            send_target(prev_x, prev_y, ROW_PREDICT);
        end else if (p < 25) begin
            send_target(16'($urandom), 16'($urandom), ROW_PREDICT);
        end else begin
            lo = mag(longint'(upper_len) - longint'(lower_len));
            hi = longint'(upper_len) + longint'(lower_len);
            if (hi > 32767) hi = 32767;
            if (lo > hi) lo = hi;
            r = $urandom_range(32'(hi), 32'(lo));
            x = longint'($urandom_range(32'(2 * r), 0)) - r;
            y = int_sqrt(r * r - x * x);
            if ($urandom_range(0, 1)) y = -y;
            send_target(x[15:0], y[15:0], ROW_PREDICT);
        end
    endtask

    // Directed rows, checked at reset link lengths.
    t_row directed[] = '{
        '{x: -16'sd1,     y: -16'sd1,     kind: ROW_DROPPED},  // equals reset state
        '{x: 16'sd0,      y: 16'sd0,      kind: ROW_UNREACH},  // origin
        '{x: 16'sd32767,  y: 16'sd32767,  kind: ROW_UNREACH},
        '{x: -16'sd32768, y: -16'sd32768, kind: ROW_UNREACH},
        '{x: 16'sd32767,  y: -16'sd32768, kind: ROW_UNREACH},
        '{x: -16'sd32768, y: 16'sd0,      kind: ROW_UNREACH},
        '{x: 16'sd3200,   y: 16'sd0,      kind: ROW_PREDICT},  // full stretch
        '{x: 16'sd0,      y: 16'sd3200,   kind: ROW_PREDICT},
        '{x: -16'sd3200,  y: 16'sd0,      kind: ROW_PREDICT},
        '{x: 16'sd0,      y: -16'sd3200,  kind: ROW_PREDICT},
        '{x: 16'sd3201,   y: 16'sd0,      kind: ROW_UNREACH},  // just past reach
        '{x: 16'sd1,      y: 16'sd0,      kind: ROW_PREDICT},  // fully folded
        '{x: 16'sd0,      y: 16'sd1,      kind: ROW_PREDICT},
        '{x: -16'sd1,     y: 16'sd0,      kind: ROW_PREDICT},
        '{x: 16'sd0,      y: -16'sd1,     kind: ROW_PREDICT},
        '{x: 16'sd2263,   y: 16'sd2263,   kind: ROW_PREDICT},
        '{x: -16'sd2263,  y: -16'sd1000,  kind: ROW_PREDICT},
        '{x: 16'sd1000,   y: 16'sd1000,   kind: ROW_PREDICT},
        '{x: 16'sd1000,   y: 16'sd1000,   kind: ROW_DROPPED},  // repeat
        '{x: 16'sd1000,   y: -16'sd1000,  kind: ROW_PREDICT},
        '{x: -16'sd1500,  y: 16'sd1200,   kind: ROW_PREDICT}
    };

    // Receiver: alternate random stalls and ready stretches.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = 1'b0;
            repeat (pick_gap()) @(negedge i_clk);
            i_out_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    // Compare each accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (angle_q.size() == 0) begin
                $error("unexpected angle word: shoulder %0d elbow %0d unreachable %0b",
                       o_shoulder_angle, o_elbow_angle, o_unreachable);
                n_errors++;
            end else begin
                t_angles e;
                e = angle_q.pop_front();
                if (o_shoulder_angle !== e.shoulder) begin
                    $error("shoulder_angle: expected %0d, actual %0d",
                           e.shoulder, o_shoulder_angle);
                    n_errors++;
                end
                if (o_elbow_angle !== e.elbow) begin
                    $error("elbow_angle: expected %0d, actual %0d", e.elbow, o_elbow_angle);
                    n_errors++;
                end
                if (o_unreachable !== e.unreach) begin
                    $error("unreachable: expected %0b, actual %0b", e.unreach, o_unreachable);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving on either channel or config.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we
            || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("two_link_arm_inverse_kinematics_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [14:0] link_set[6][2];
        n_errors    = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_target_x  = '0;
        i_target_y  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        upper_len   = LINK_RESET;
        lower_len   = LINK_RESET;
        prev_x      = 16'hFFFF;
        prev_y      = 16'hFFFF;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) send_target(directed[i].x, directed[i].y, directed[i].kind);

        link_set = '{'{15'd1600, 15'd1600}, '{15'd1, 15'd1}, '{15'd32767, 15'd32767},
                     '{15'd32767, 15'd1}, '{15'd0, 15'd500}, '{15'd0, 15'd0}};
        link_set[5][0] = 15'($urandom_range(1, 20000));
        link_set[5][1] = 15'($urandom_range(1, 20000));

        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6) begin
                // back to random lengths, plus writes to unused indexes
                write_reg(2'd2, 15'($urandom));
                write_reg(2'd3, 15'($urandom));
                write_reg(CFG_UPPER, 15'($urandom_range(1, 32767)));
                write_reg(CFG_LOWER, 15'($urandom_range(1, 32767)));
            end else begin
                write_reg(CFG_UPPER, link_set[ph][0]);
                write_reg(CFG_LOWER, link_set[ph][1]);
            end
            repeat (270) send_random();
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (angle_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("two_link_arm_inverse_kinematics_unit test passed");
        end else begin
            $display("two_link_arm_inverse_kinematics_unit test failed");
        end
        $finish;
    end
endmodule
